### hdl/box_blur_3x3_rgb_macros.svh
// Assertion macros shared by the checker of the box blur block.
// The enclosing module supplies signals named clock and reset.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define BB3_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bb3 check failed");

// Next-cycle implication, switched off while reset is high
`define BB3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bb3 check failed");

// Next-cycle implication that also covers the reset itself
`define BB3_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bb3 check failed");

`endif

### hdl/bb3_pkg.sv
package bb3_pkg;

   // Field widths
   localparam int CHAN_W       = 8;
   localparam int ROW_W        = 12;
   localparam int COL_W        = 10;
   localparam int WREG_W       = 11;
   localparam int HREG_W       = 13;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 48;
   localparam int RSP_PAD_W    = 2;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 13;

   // Geometry limits and register reset values
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // Divide by nine: floor(s * 3641 / 2^15) is exact for every 3x3 channel sum
   localparam int SUM_W = 12;
   localparam logic [SUM_W-1:0] RECIP9 = 12'd3641;
   localparam int RECIP_SHIFT = 15;

   // Blue in the lowest bits, as on the bus
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // One line store entry: row r-2 above row r-1
   typedef struct packed {
      pixel_type prev2;
      pixel_type prev;
   } line_type;

   // One result item
   typedef struct packed {
      logic             frame_end;
      logic             run_last;
      pixel_type        pix;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } rsp_item_type;

   // What a pixel in the work stage has to emit
   typedef struct packed {
      logic has_main;
      logic interior;
      logic has_edge;
      logic has_copy;
      logic last_col;
   } s1_flags_type;

   function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [2*SUM_W-1:0] prod;
      prod = (2*SUM_W)'(s) * (2*SUM_W)'(RECIP9);
      return prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
   endfunction

   // Per-channel truncated mean of nine pixels
   function automatic pixel_type mean9(input pixel_type [8:0] nb);
      logic [SUM_W-1:0] sum_b;
      logic [SUM_W-1:0] sum_g;
      logic [SUM_W-1:0] sum_r;
      pixel_type res;
      sum_b = '0;
      sum_g = '0;
      sum_r = '0;
      for (int i = 0; i < 9; i++) begin
         sum_b = sum_b + SUM_W'(nb[i].blue);
         sum_g = sum_g + SUM_W'(nb[i].green);
         sum_r = sum_r + SUM_W'(nb[i].red);
      end
      res.blue  = div9(sum_b);
      res.green = div9(sum_g);
      res.red   = div9(sum_r);
      return res;
   endfunction

endpackage

### hdl/box_blur_3x3_rgb.sv
// Channel   Dir  Payload (low bit up)                                Marks
// req_*     in   tdata: in_blue, in_green, in_red                    -
// rsp_*     out  tdata: out_row, out_col, out_blue, out_green,       tlast: run_last
//                out_red, 2 pad bits                                 tuser: frame_end
// csr_*     in   csr_addr 0: image_width, 1: image_height            write only
//
// One pixel is taken per clock while the output slots keep up. Its results leave
// one per clock, while the consumer is ready, from a three-slot output register,
// so a pixel with two or three results (end of a row, last row) holds the input
// back until only its last result is left. Line store read and window form the work stage.
// Reset clears counters, window and output slots; line stores are not cleared.
// Either side may stall at any time without loss.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bb3_pkg::REQ_DATA_W-1:0]  req_tdata,   // in_blue, in_green, in_red
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bb3_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // out_row, out_col, out_blue,
                                                        // out_green, out_red, pad
   output logic                            rsp_tlast,
   output logic [0:0]                      rsp_tuser,   // frame_end
   input  logic                            csr_we,
   input  logic [bb3_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bb3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   // Configuration
   logic [WREG_W-1:0] width_ff, width_in;
   logic [HREG_W-1:0] height_ff, height_in;
   logic [WREG_W-1:0] w_eff;
   logic [HREG_W-1:0] h_eff;

   // Position of the next pixel
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   // Work stage
   logic             s1_valid_ff, s1_valid_in;
   pixel_type        s1_px_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [AW-1:0]    s1_addr_ff;
   s1_flags_type     s1_flags_ff, s1_flags_in;

   // Line store and bypass
   line_type      line_mem [MAX_WIDTH];
   line_type      mem_q_ff;
   logic          fwd_ff, fwd_in;
   line_type      fwd_data_ff;
   line_type      line_rd;
   line_type      line_wr;
   logic [AW-1:0] acc_addr;

   // 3x3 window: columns c-2 then c-1, rows r-2, r-1, r
   pixel_type win_ff [6];
   pixel_type win_in [6];

   // Output slots
   rsp_item_type slot_ff [3];
   rsp_item_type slot_in [3];
   logic [2:0]   mask_ff, mask_in;
   rsp_item_type rsp_item;

   logic accept;
   logic s1_fire;
   logic rsp_fire;
   logic last_col;
   logic last_row;
   pixel_type [8:0] nb;
   pixel_type blur_px;

   // Effective geometry
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WREG_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WREG_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = HREG_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HREG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Handshakes
   always_comb begin
      s1_fire = s1_valid_ff &&
                (mask_ff == 3'b000 ||
                 ((mask_ff == 3'b001 || mask_ff == 3'b010 || mask_ff == 3'b100) &&
                  rsp_tready));
      req_tready = !s1_valid_ff || s1_fire;
      accept     = req_tvalid && req_tready;
      rsp_tvalid = (mask_ff != 3'b000);
      rsp_fire   = rsp_tvalid && rsp_tready;
   end

   // Configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[WREG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[HREG_W-1:0];
            default: ;
         endcase
      end
   end

   // Input side: classify the pixel and advance the counters
   always_comb begin
      last_col = ({1'b0, col_ff} + WREG_W'(1)) >= w_eff;
      last_row = ({1'b0, row_ff} + HREG_W'(1)) >= h_eff;
      acc_addr = (32'(col_ff) < MAX_WIDTH) ? AW'(col_ff) : AW'(MAX_WIDTH - 1);

      s1_flags_in.has_main = (row_ff != '0) && (col_ff != '0);
      s1_flags_in.interior = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2)) &&
                             ({1'b0, col_ff} <= w_eff - WREG_W'(1)) &&
                             ({1'b0, row_ff} <= h_eff - HREG_W'(1));
      s1_flags_in.has_edge = (row_ff != '0) && last_col;
      s1_flags_in.has_copy = last_row;
      s1_flags_in.last_col = last_col;

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   end

   // Work stage: line data with bypass, window, blur
   always_comb begin
      line_rd       = fwd_ff ? fwd_data_ff : mem_q_ff;
      line_wr.prev2 = line_rd.prev;
      line_wr.prev  = s1_px_ff;
      fwd_in        = s1_fire && (acc_addr == s1_addr_ff);

      for (int i = 0; i < 6; i++) begin
         nb[i] = win_ff[i];
      end
      nb[6]   = line_rd.prev2;
      nb[7]   = line_rd.prev;
      nb[8]   = s1_px_ff;
      blur_px = mean9(nb);

      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      if (s1_fire) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i] = win_ff[i+3];
         end
         win_in[3] = line_rd.prev2;
         win_in[4] = line_rd.prev;
         win_in[5] = s1_px_ff;
      end
   end

   // Output slots: load all results of a pixel, then hand them out lowest first
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = slot_ff[i];
      end
      mask_in = mask_ff;
      if (s1_fire) begin
         slot_in[0].row       = s1_row_ff - ROW_W'(1);
         slot_in[0].col       = s1_col_ff - COL_W'(1);
         slot_in[0].pix       = s1_flags_ff.interior ? blur_px : win_ff[4];
         slot_in[0].run_last  = !s1_flags_ff.has_edge && !s1_flags_ff.has_copy;
         slot_in[0].frame_end = 1'b0;

         slot_in[1].row       = s1_row_ff - ROW_W'(1);
         slot_in[1].col       = s1_col_ff;
         slot_in[1].pix       = line_rd.prev;
         slot_in[1].run_last  = !s1_flags_ff.has_copy;
         slot_in[1].frame_end = 1'b0;

         slot_in[2].row       = s1_row_ff;
         slot_in[2].col       = s1_col_ff;
         slot_in[2].pix       = s1_px_ff;
         slot_in[2].run_last  = 1'b1;
         slot_in[2].frame_end = s1_flags_ff.last_col;

         mask_in = {s1_flags_ff.has_copy, s1_flags_ff.has_edge, s1_flags_ff.has_main};
      end else if (rsp_fire) begin
         mask_in = mask_ff & (mask_ff - 3'd1);
      end

      if (mask_ff[0]) begin
         rsp_item = slot_ff[0];
      end else if (mask_ff[1]) begin
         rsp_item = slot_ff[1];
      end else begin
         rsp_item = slot_ff[2];
      end
      rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_item.pix, rsp_item.col, rsp_item.row};
      rsp_tlast = rsp_item.run_last;
      rsp_tuser = rsp_item.frame_end;
   end

   // Line store: read on accept, write back when the pixel leaves the work stage
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         line_mem[s1_addr_ff] <= line_wr;
      end
      if (accept) begin
         mem_q_ff <= line_mem[acc_addr];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= pixel_type'(req_tdata);
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         s1_addr_ff  <= acc_addr;
         s1_flags_ff <= s1_flags_in;
         fwd_data_ff <= line_wr;
      end
      for (int i = 0; i < 3; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         mask_ff     <= 3'b000;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         mask_ff <= mask_in;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

### hdl/bb3_checker.sv
`include "box_blur_3x3_rgb_macros.svh"

module bb3_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bb3_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic [0:0]                      rsp_tuser
);
   import bb3_pkg::*;

   // A result waiting on a stalled consumer holds still
   `BB3_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // Input is only held off while a result is pending
   `BB3_ASSERT_NOW(a_no_idle_stall, !req_tready, rsp_tvalid)

   // The frame's final item always closes its run
   `BB3_ASSERT_NOW(a_frame_end_last, rsp_tvalid && rsp_tuser[0], rsp_tlast)

   // Nothing comes out straight after reset
   `BB3_ASSERT_ALWAYS_NEXT(a_reset_quiet, reset, !rsp_tvalid)

   // Pad bits of the result item stay zero
   `BB3_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:RSP_DATA_W-RSP_PAD_W] == '0)

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);
